>>> src/multi_stack_fixed_partition_top_macros.svh
// Assertion macros shared by the stack block. Every module that uses them
// has ports named i_clk and i_rst_n.
`ifndef MULTI_STACK_FIXED_PARTITION_TOP_MACROS_SVH
`define MULTI_STACK_FIXED_PARTITION_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/msfp_pkg.sv
package msfp_pkg;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Operation handed from the front to the back.
    typedef struct packed {
        logic    wr;
        logic    rd;
        t_status status;
    } t_op_ctrl;

    localparam int SIZE_W  = 5;
    localparam int FIELD_W = 32;

endpackage

>>> src/multi_stack_fixed_partition_top.sv
// Several LIFO stacks sharing one data memory, each stack owning a fixed
// partition of MAX_DEPTH words; pushes use at most the first stack_size.
// Input channel: an operation transfers at a clock edge with start high and
// busy low. i_mode selects push or pop, i_stack_index the stack, and
// i_push_value the word that a push stores.
// Result channel: every operation yields one result, held in the queue and
// then in the back's registers, shown for one cycle with o_strobe high:
// o_pop_value carries the popped word (zero otherwise), o_status ok/full/empty.
// One operation can transfer every cycle; the front updates the fill count
// in the cycle of the transfer and the back does one memory access a cycle,
// so the back empties the two-entry queue between them as fast as the front
// fills it, and busy never rises.
// Configuration: i_cfg_data sets stack_size when i_cfg_valid and
// o_cfg_ready are both high; write it only while no operation is in flight.
// Reset empties every stack and sets stack_size to 16. The data memory is
// not cleared. The receiver cannot stall; each result must be taken in its
// cycle.
module multi_stack_fixed_partition_top import msfp_pkg::*; #(
    parameter int NUM_STACKS = 4,
    parameter int MAX_DEPTH  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [1:0]         i_stack_index,
    input  logic [FIELD_W-1:0] i_push_value,
    output logic               o_strobe,
    output logic [FIELD_W-1:0] o_pop_value,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SIZE_W-1:0]  i_cfg_data
);

    localparam int WORDS = NUM_STACKS * MAX_DEPTH;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CTW   = $bits(t_op_ctrl);
    localparam int QW    = CTW + AW + DATA_WIDTH;

    logic [SIZE_W-1:0]     r_stack_size;
    logic                  accept;
    logic                  q_wr;
    t_op_ctrl              f_ctrl;
    logic [AW-1:0]         f_addr;
    logic [DATA_WIDTH-1:0] f_data;
    logic [QW-1:0]         q_rd_data;
    logic                  q_rd;
    logic                  q_full;
    logic                  q_empty;
    t_op_ctrl              b_ctrl;
    logic [AW-1:0]         b_addr;
    logic [DATA_WIDTH-1:0] b_data;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_full;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_size <= SIZE_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stack_size <= i_cfg_data;
        end
    end

    msfp_front #(
        .NUM_STACKS (NUM_STACKS),
        .MAX_DEPTH  (MAX_DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_mode        (t_mode'(i_mode)),
        .i_stack_index (i_stack_index),
        .i_push_value  (i_push_value),
        .i_stack_size  (r_stack_size),
        .o_q_wr        (q_wr),
        .o_ctrl        (f_ctrl),
        .o_addr        (f_addr),
        .o_data        (f_data)
    );

    msfp_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data ({f_ctrl, f_addr, f_data}),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    assign {b_ctrl, b_addr, b_data} = q_rd_data;

    msfp_back #(
        .NUM_STACKS (NUM_STACKS),
        .MAX_DEPTH  (MAX_DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!q_empty),
        .i_ctrl      (b_ctrl),
        .i_addr      (b_addr),
        .i_data      (b_data),
        .o_q_rd      (q_rd),
        .o_strobe    (o_strobe),
        .o_pop_value (o_pop_value),
        .o_status    (o_status)
    );

endmodule

>>> src/msfp_queue.sv
`include "multi_stack_fixed_partition_top_macros.svh"

module msfp_queue import msfp_pkg::*; #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CNTW-1:0]  r_count;
    logic [PW-1:0]    n_wptr;
    logic [PW-1:0]    n_rptr;
    logic [CNTW-1:0]  n_count;

    assign o_full    = (r_count == CNTW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_wr) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_rd) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    `MSFP_ASSERT_SAME(a_no_write_when_full, i_wr, !o_full, "queue written while full")
    `MSFP_ASSERT_SAME(a_no_read_when_empty, i_rd, !o_empty, "queue read while empty")

endmodule

>>> src/msfp_front.sv
`include "multi_stack_fixed_partition_top_macros.svh"

module msfp_front import msfp_pkg::*; #(
    parameter int NUM_STACKS = 4,
    parameter int MAX_DEPTH  = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  t_mode                 i_mode,
    input  logic [1:0]            i_stack_index,
    input  logic [FIELD_W-1:0]    i_push_value,
    input  logic [SIZE_W-1:0]     i_stack_size,
    output logic                  o_q_wr,
    output t_op_ctrl              o_ctrl,
    output logic [AW-1:0]         o_addr,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam int CW   = $clog2(MAX_DEPTH + 1);
    localparam int SW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CMPW = (CW > SIZE_W) ? CW : SIZE_W;

    logic [CW-1:0]   r_fill [NUM_STACKS];
    logic [7:0]      sel_ext;
    logic [SW-1:0]   sel;
    logic            in_range;
    logic [CW-1:0]   cnt;
    logic [CW-1:0]   op_cnt;
    logic [CMPW-1:0] size_ext;
    logic [CMPW-1:0] max_ext;
    logic [CMPW-1:0] cap;
    logic            is_full;
    logic            is_empty;
    t_op_ctrl        ctrl;

    always_comb begin
        sel_ext  = 8'(i_stack_index);
        sel      = sel_ext[SW-1:0];
        in_range = (sel_ext < 8'(NUM_STACKS));
        cnt      = in_range ? r_fill[sel] : '0;
        size_ext = CMPW'(i_stack_size);
        max_ext  = CMPW'(MAX_DEPTH);
        cap      = (size_ext > max_ext) ? max_ext : size_ext;
        is_full  = (CMPW'(cnt) >= cap);
        is_empty = (cnt == '0);
    end

    always_comb begin
        ctrl = '{wr: 1'b0, rd: 1'b0, status: ST_OK};
        if (!in_range) begin
            ctrl.status = (i_mode == MODE_POP) ? ST_EMPTY : ST_FULL;
        end else begin
            unique case (i_mode)
                MODE_PUSH: begin
                    if (is_full) begin
                        ctrl.status = ST_FULL;
                    end else begin
                        ctrl.wr = 1'b1;
                    end
                end
                MODE_POP: begin
                    if (is_empty) begin
                        ctrl.status = ST_EMPTY;
                    end else begin
                        ctrl.rd = 1'b1;
                    end
                end
                default: ctrl.status = ST_OK;
            endcase
        end
        op_cnt = ctrl.rd ? cnt - 1'b1 : cnt;
    end

    assign o_q_wr = i_accept;
    assign o_ctrl = ctrl;
    assign o_addr = AW'(int'(sel) * MAX_DEPTH + int'(op_cnt));
    assign o_data = DATA_WIDTH'({32'b0, i_push_value});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STACKS; k++) begin
                r_fill[k] <= '0;
            end
        end else if (i_accept) begin
            if (ctrl.wr) begin
                r_fill[sel] <= cnt + 1'b1;
            end else if (ctrl.rd) begin
                r_fill[sel] <= op_cnt;
            end
        end
    end

    `MSFP_ASSERT_SAME(a_push_below_depth, i_accept && ctrl.wr, CMPW'(cnt) < max_ext, "push past depth")
    `MSFP_ASSERT_SAME(a_one_access, i_accept, !(ctrl.wr && ctrl.rd), "push and pop together")

endmodule

>>> src/msfp_back.sv
`include "multi_stack_fixed_partition_top_macros.svh"

module msfp_back import msfp_pkg::*; #(
    parameter int NUM_STACKS = 4,
    parameter int MAX_DEPTH  = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_op_ctrl              i_ctrl,
    input  logic [AW-1:0]         i_addr,
    input  logic [DATA_WIDTH-1:0] i_data,
    output logic                  o_q_rd,
    output logic                  o_strobe,
    output logic [FIELD_W-1:0]    o_pop_value,
    output logic [1:0]            o_status
);

    localparam int WORDS = NUM_STACKS * MAX_DEPTH;

    logic [DATA_WIDTH-1:0] r_mem [WORDS];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_strobe;
    logic                  r_rd;
    t_status               r_status;
    logic [63:0]           rd_ext;

    assign o_q_rd = i_q_valid;

    always_ff @(posedge i_clk) begin
        if (i_q_valid && i_ctrl.wr) begin
            r_mem[i_addr] <= i_data;
        end
        if (i_q_valid && i_ctrl.rd) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_rd     <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_strobe <= i_q_valid;
            r_rd     <= i_q_valid && i_ctrl.rd;
            r_status <= i_ctrl.status;
        end
    end

    always_comb begin
        rd_ext      = 64'(r_rd_data);
        o_strobe    = r_strobe;
        o_status    = r_status;
        o_pop_value = r_rd ? rd_ext[FIELD_W-1:0] : '0;
    end

    `MSFP_ASSERT_NEXT(a_strobe_follows_op, i_q_valid, o_strobe, "result transfer missing")
    `MSFP_ASSERT_NEXT(a_no_stray_strobe, !i_q_valid, !o_strobe, "result without operation")

endmodule

>>> tb/sv/msfp_checker.sv
`timescale 1ns / 100ps

module msfp_checker import msfp_pkg::*; #(
    parameter int NUM_STACKS = 4,
    parameter int MAX_DEPTH  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_mode,
    input  logic [1:0]         i_stack_index,
    input  logic [FIELD_W-1:0] i_push_value,
    input  logic               i_strobe,
    input  logic [FIELD_W-1:0] i_pop_value,
    input  logic [1:0]         i_status,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_full_seen,
    output int                 o_empty_seen
);

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        t_status            status;
    } t_stack_result;

    logic [FIELD_W-1:0] stack_words [NUM_STACKS*MAX_DEPTH];
    int unsigned        stack_depth [NUM_STACKS];
    logic [SIZE_W-1:0]  size_reg;
    t_stack_result      result_q [$];
    int                 fail_count   = 0;
    int                 pending      = 0;
    int                 full_seen    = 0;
    int                 empty_seen   = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_full_seen  = full_seen;
    assign o_empty_seen = empty_seen;

    task automatic report_fail(string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic t_stack_result predict_stack_op(t_mode op, int sel,
                                                       logic [FIELD_W-1:0] word);
        t_stack_result res;
        int unsigned   cap;
        res.value  = '0;
        res.status = ST_OK;
        cap = (size_reg > MAX_DEPTH) ? MAX_DEPTH : size_reg;
        if (sel >= NUM_STACKS) begin
            res.status = (op == MODE_POP) ? ST_EMPTY : ST_FULL;
        end else if (op == MODE_PUSH) begin
            if (stack_depth[sel] >= cap) begin
                res.status = ST_FULL;
            end else begin
                stack_words[sel*MAX_DEPTH + stack_depth[sel]] = word;
                stack_depth[sel]++;
            end
        end else begin
            if (stack_depth[sel] == 0) begin
                res.status = ST_EMPTY;
            end else begin
                stack_depth[sel]--;
                res.value = stack_words[sel*MAX_DEPTH + stack_depth[sel]];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_stack_result exp_res;
        if (!i_rst_n) begin
            foreach (stack_depth[i]) stack_depth[i] = 0;
            size_reg = 5'd16;
            result_q.delete();
        end else begin
            if (i_strobe) begin
                if (result_q.size() == 0) begin
                    report_fail($sformatf("result with nothing outstanding: value %h status %0d",
                                          i_pop_value, i_status));
                end else begin
                    exp_res = result_q.pop_front();
                    if (i_pop_value !== exp_res.value) begin
                        report_fail($sformatf("pop_value expected %h actual %h",
                                              exp_res.value, i_pop_value));
                    end
                    if (i_status !== exp_res.status) begin
                        report_fail($sformatf("status expected %0d actual %0d",
                                              exp_res.status, i_status));
                    end
                end
            end
            if (i_start && !i_busy) begin
                exp_res = predict_stack_op(t_mode'(i_mode), i_stack_index, i_push_value);
                if (exp_res.status == ST_FULL) full_seen++;
                if (exp_res.status == ST_EMPTY) empty_seen++;
                result_q.push_back(exp_res);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                size_reg = i_cfg_data;
            end
        end
        pending = result_q.size();
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import msfp_pkg::*;

    localparam int NUM_STACKS  = 4;
    localparam int MAX_DEPTH   = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 60;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    logic               mode        = 1'b0;
    logic [1:0]         stack_index = '0;
    logic [FIELD_W-1:0] push_value  = '0;
    logic               strobe;
    logic [FIELD_W-1:0] pop_value;
    logic [1:0]         status;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [SIZE_W-1:0]  cfg_data    = '0;

    int fail_count;
    int pending;
    int full_seen;
    int empty_seen;
    int cycle_count  = 0;
    int push_count   = 0;
    int pop_count    = 0;
    int size_writes  = 0;
    int size_plan [NUM_PHASES] = '{31, 2, 16, 0, 5, 1, 17, 16};
    int push_plan [NUM_PHASES] = '{75, 40, 65, 50, 80, 35, 55, 60};

    always #5 clk = ~clk;

    multi_stack_fixed_partition_top #(
        .NUM_STACKS (NUM_STACKS),
        .MAX_DEPTH  (MAX_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (mode),
        .i_stack_index (stack_index),
        .i_push_value  (push_value),
        .o_strobe      (strobe),
        .o_pop_value   (pop_value),
        .o_status      (status),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    msfp_checker #(
        .NUM_STACKS (NUM_STACKS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_mode        (mode),
        .i_stack_index (stack_index),
        .i_push_value  (push_value),
        .i_strobe      (strobe),
        .i_pop_value   (pop_value),
        .i_status      (status),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_full_seen   (full_seen),
        .o_empty_seen  (empty_seen)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** multi_stack_fixed_partition_top: FAILED **");
            $finish;
        end
    end

    task automatic send_op(t_mode op, int sel, logic [FIELD_W-1:0] word);
        @(negedge clk);
        start       = 1'b1;
        mode        = op;
        stack_index = sel[1:0];
        push_value  = word;
        do @(posedge clk); while (busy);
        if (op == MODE_PUSH) push_count++;
        else pop_count++;
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // Lets every outstanding operation finish so the size may be changed.
    task automatic drain();
        idle_cycles(1);
        while (pending != 0) @(negedge clk);
        idle_cycles(4);
    endtask

    task automatic write_size(int value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value[SIZE_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        size_writes++;
    endtask

    initial begin
        t_mode              op;
        int                 sel;
        int                 hot;
        int                 push_pct;
        int                 idle_pct;
        logic [FIELD_W-1:0] word;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_op(MODE_POP,  0, 32'hDEAD_BEEF);
        send_op(MODE_PUSH, 0, 32'h8000_0000);
        send_op(MODE_PUSH, 0, 32'h7FFF_FFFF);
        send_op(MODE_PUSH, 0, 32'hFFFF_FFFF);
        send_op(MODE_PUSH, 0, 32'h0000_0000);
        send_op(MODE_PUSH, 1, 32'hAAAA_AAAA);
        send_op(MODE_PUSH, 2, 32'h5555_5555);
        send_op(MODE_PUSH, 3, 32'h1234_5678);
        send_op(MODE_POP,  0, 32'hFFFF_FFFF);

        // Size lowered below the fill count: pushes refused, pops still drain.
        drain();
        write_size(1);
        send_op(MODE_PUSH, 0, 32'h0BAD_F00D);
        send_op(MODE_PUSH, 3, 32'h0BAD_F00D);
        send_op(MODE_POP,  3, 32'h0);
        send_op(MODE_PUSH, 3, 32'hCAFE_0001);
        send_op(MODE_POP,  1, 32'h0);
        send_op(MODE_PUSH, 1, 32'hCAFE_0002);

        // A size of zero refuses every push.
        drain();
        write_size(0);
        send_op(MODE_PUSH, 2, 32'h0F0F_0F0F);
        send_op(MODE_POP,  2, 32'h0);
        send_op(MODE_POP,  2, 32'h0);
        send_op(MODE_PUSH, 1, 32'hF0F0_F0F0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            write_size((ph == 6) ? $urandom_range(0, 31) : size_plan[ph]);
            push_pct = push_plan[ph];
            hot      = $urandom_range(0, NUM_STACKS - 1);
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 25;
                default: idle_pct = 60;
            endcase
            if (ph == NUM_PHASES - 1) idle_pct = 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                op  = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
                sel = $urandom_range(0, 1) ? hot : $urandom_range(0, NUM_STACKS - 1);
                case ($urandom_range(0, 11))
                    0: word = 32'h8000_0000;
                    1: word = 32'h7FFF_FFFF;
                    2: word = 32'hFFFF_FFFF;
                    3: word = 32'h0000_0000;
                    default: word = $urandom;
                endcase
                send_op(op, sel, word);
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                    idle_cycles($urandom_range(1, 7));
                end
            end
        end

        drain();
        $display("Ran %0d pushes and %0d pops across %0d stack size settings.",
                 push_count, pop_count, size_writes);
        $display("Saw %0d refused pushes on full stacks and %0d pops from empty stacks.",
                 full_seen, empty_seen);
        if (fail_count == 0) begin
            $display("** multi_stack_fixed_partition_top: PASSED **");
        end else begin
            $display("** multi_stack_fixed_partition_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/msfp_pkg.sv
src/msfp_queue.sv
src/msfp_front.sv
src/msfp_back.sv
src/multi_stack_fixed_partition_top.sv
tb/sv/msfp_checker.sv
tb/sv/tb.sv
